// File: hdl/cfs_pkg.sv
`timescale 1ns / 1ps

package cfs_pkg;

    localparam int MAX_FIELDS  = 64;
    localparam int MASK_W      = 64;
    localparam int POS_W       = 7;
    localparam int SLOT_W      = 6;
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    localparam logic [7:0] NEWLINE_BYTE = 8'h0A;

    localparam logic [7:0]        DELIMITER_RST    = 8'd44;
    localparam logic [15:0]       HEADER_LINES_RST = 16'd0;
    localparam logic [MASK_W-1:0] FIELD_MASK_RST   = 64'd1;

    localparam logic [MASK_W-1:0] USED_LIMIT =
        (MAX_FIELDS >= MASK_W) ? {MASK_W{1'b1}} : ((64'd1 << MAX_FIELDS) - 64'd1);

    typedef enum logic [1:0] {
        CFG_DELIMITER    = 2'd0,
        CFG_HEADER_LINES = 2'd1,
        CFG_FIELD_MASK   = 2'd2
    } t_cfg_index;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       stream_end;
    } t_in;

    typedef struct packed {
        logic [7:0]        out_byte;
        logic              byte_valid;
        logic [SLOT_W-1:0] slot;
        logic              field_done;
        logic              record_done;
        logic              status;
    } t_out;

    typedef enum logic [2:0] {
        KIND_BYTE,
        KIND_FIELD_END,
        KIND_FIELD_REC_END,
        KIND_REC_END,
        KIND_HDR_ERR
    } t_kind;

    typedef struct packed {
        t_kind             kind;
        logic [7:0]        data;
        logic [SLOT_W-1:0] slot;
    } t_cmd;

endpackage

// File: hdl/cfs_front.sv
`timescale 1ns / 1ps

module cfs_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [1:0]           i_cfg_index,
    input  logic [63:0]          i_cfg_data,
    input  logic                 i_accept,
    input  cfs_pkg::t_in         i_item,
    output logic                 o_push,
    output cfs_pkg::t_cmd        o_cmd
);
    import cfs_pkg::*;

    typedef enum logic [2:0] {
        M_HEADER,
        M_START,
        M_SEL,
        M_UNSEL,
        M_DISCARD
    } t_mode;

    t_mode              r_mode, n_mode;
    logic [15:0]        r_lines_left, n_lines_left;
    logic [POS_W-1:0]   r_pos, n_pos;
    logic [SLOT_W-1:0]  r_slot, n_slot;
    logic               r_open, n_open;
    logic [7:0]         r_delim;
    logic [15:0]        r_header_lines;
    logic [MASK_W-1:0]  r_mask;

    logic [MASK_W-1:0]  used_mask;
    logic               pos_in_range;
    logic               pos_selected;
    logic               fields_left;
    logic [15:0]        lines_dec;

    assign used_mask    = r_mask & USED_LIMIT;
    assign pos_in_range = (r_pos < POS_W'(MASK_W));
    assign pos_selected = pos_in_range && used_mask[r_pos[POS_W-2:0]];
    assign fields_left  = pos_in_range && (|(used_mask >> r_pos));
    assign lines_dec    = (r_lines_left != 16'd0) ? r_lines_left - 16'd1 : r_lines_left;

    always_comb begin
        n_mode       = r_mode;
        n_lines_left = r_lines_left;
        n_pos        = r_pos;
        n_slot       = r_slot;
        n_open       = r_open;
        o_push       = 1'b0;
        o_cmd.kind   = KIND_BYTE;
        o_cmd.data   = i_item.in_byte;
        o_cmd.slot   = r_slot;

        if (i_item.stream_end) begin
            if (r_mode == M_HEADER && r_lines_left != 16'd0) begin
                o_push     = 1'b1;
                o_cmd.kind = KIND_HDR_ERR;
            end else if (r_mode == M_SEL) begin
                o_push     = 1'b1;
                o_cmd.kind = KIND_FIELD_REC_END;
            end else if (r_open) begin
                o_push     = 1'b1;
                o_cmd.kind = KIND_REC_END;
            end
            n_lines_left = r_header_lines;
            n_mode       = (r_header_lines != 16'd0) ? M_HEADER : M_START;
            n_pos        = '0;
            n_slot       = '0;
            n_open       = 1'b0;
        end else if (r_mode == M_HEADER) begin
            if (i_item.in_byte == NEWLINE_BYTE) begin
                n_lines_left = lines_dec;
                if (lines_dec == 16'd0) begin
                    n_mode = M_START;
                end
            end
        end else if (i_item.in_byte == r_delim) begin
            case (r_mode)
                M_SEL: begin
                    o_push     = 1'b1;
                    o_cmd.kind = KIND_FIELD_END;
                    n_slot     = r_slot + SLOT_W'(1);
                    n_pos      = r_pos + POS_W'(1);
                    n_mode     = M_START;
                end
                M_UNSEL: begin
                    n_pos  = r_pos + POS_W'(1);
                    n_mode = M_START;
                end
                default: begin
                end
            endcase
        end else if (i_item.in_byte == NEWLINE_BYTE) begin
            o_push     = 1'b1;
            o_cmd.kind = (r_mode == M_SEL || (r_mode == M_START && pos_selected)) ?
                         KIND_FIELD_REC_END : KIND_REC_END;
            n_mode     = M_START;
            n_pos      = '0;
            n_slot     = '0;
            n_open     = 1'b0;
        end else begin
            n_open = 1'b1;
            if (r_mode == M_START) begin
                if (!fields_left) begin
                    n_mode = M_DISCARD;
                end else if (pos_selected) begin
                    n_mode = M_SEL;
                end else begin
                    n_mode = M_UNSEL;
                end
            end
            if (n_mode == M_SEL) begin
                o_push     = 1'b1;
                o_cmd.kind = KIND_BYTE;
            end
        end

        if (!i_accept) begin
            o_push = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode         <= M_START;
            r_lines_left   <= HEADER_LINES_RST;
            r_pos          <= '0;
            r_slot         <= '0;
            r_open         <= 1'b0;
            r_delim        <= DELIMITER_RST;
            r_header_lines <= HEADER_LINES_RST;
            r_mask         <= FIELD_MASK_RST;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_DELIMITER: begin
                        r_delim <= i_cfg_data[7:0];
                    end
                    CFG_HEADER_LINES: begin
                        r_header_lines <= i_cfg_data[15:0];
                    end
                    CFG_FIELD_MASK: begin
                        r_mask <= i_cfg_data;
                    end
                    default: begin
                    end
                endcase
            end
            if (i_cfg_we && i_cfg_index == CFG_HEADER_LINES) begin
                r_lines_left <= i_cfg_data[15:0];
                r_mode       <= (i_cfg_data[15:0] != 16'd0) ? M_HEADER : M_START;
                r_pos        <= '0;
                r_slot       <= '0;
                r_open       <= 1'b0;
            end else if (i_accept) begin
                r_mode       <= n_mode;
                r_lines_left <= n_lines_left;
                r_pos        <= n_pos;
                r_slot       <= n_slot;
                r_open       <= n_open;
            end
        end
    end

endmodule

// File: hdl/cfs_queue.sv
`timescale 1ns / 1ps

module cfs_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  cfs_pkg::t_cmd  i_cmd,
    output logic           o_full,
    input  logic           i_pop,
    output logic           o_empty,
    output cfs_pkg::t_cmd  o_cmd
);
    import cfs_pkg::*;

    t_cmd                r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0] r_wr_ptr;
    logic [QUEUE_AW-1:0] r_rd_ptr;
    logic [QUEUE_AW:0]   r_count;

    assign o_full  = (r_count == (QUEUE_AW + 1)'(QUEUE_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_cmd   = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + QUEUE_AW'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + QUEUE_AW'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + (QUEUE_AW + 1)'(1);
            end else if (!i_push && i_pop) begin
                r_count <= r_count - (QUEUE_AW + 1)'(1);
            end
        end
    end

endmodule

// File: hdl/cfs_back.sv
`timescale 1ns / 1ps

module cfs_back (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_empty,
    input  cfs_pkg::t_cmd  i_cmd,
    output logic           o_pop,
    output logic           o_out_valid,
    output cfs_pkg::t_out  o_out_data,
    input  logic           i_out_stall
);
    import cfs_pkg::*;

    logic r_valid;
    t_out r_data;
    t_out n_data;

    assign o_pop       = !i_empty && (!r_valid || !i_out_stall);
    assign o_out_valid = r_valid;
    assign o_out_data  = r_data;

    always_comb begin
        n_data = '0;
        case (i_cmd.kind)
            KIND_BYTE: begin
                n_data.out_byte   = i_cmd.data;
                n_data.byte_valid = 1'b1;
                n_data.slot       = i_cmd.slot;
            end
            KIND_FIELD_END: begin
                n_data.slot       = i_cmd.slot;
                n_data.field_done = 1'b1;
            end
            KIND_FIELD_REC_END: begin
                n_data.slot        = i_cmd.slot;
                n_data.field_done  = 1'b1;
                n_data.record_done = 1'b1;
            end
            KIND_REC_END: begin
                n_data.record_done = 1'b1;
            end
            KIND_HDR_ERR: begin
                n_data.status = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_data <= n_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_pop) begin
            r_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_valid <= 1'b0;
        end
    end

endmodule

// File: hdl/csv_field_selector_top.sv
`timescale 1ns / 1ps

// Selects fields from a delimited text stream at one byte per clock. A parser
// stage classifies each accepted byte and, when it yields a result, pushes it
// into a four-entry queue; an output register drains that queue, so input and
// output stall independently and a byte that yields no result waits only while
// the queue is full. A result is written into the queue and then into the
// output register before output valid rises. The input stalls only while the
// queue is full. The configuration port is always ready and a write is seen
// by the next byte; writing header_lines restarts the parser as at reset.

module csv_field_selector_top (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cfg_valid,
    output logic           o_cfg_ready,
    input  logic [1:0]     i_cfg_index,
    input  logic [63:0]    i_cfg_data,
    input  logic           i_in_valid,
    output logic           o_in_stall,
    input  cfs_pkg::t_in   i_in_data,
    output logic           o_out_valid,
    input  logic           i_out_stall,
    output cfs_pkg::t_out  o_out_data
);
    import cfs_pkg::*;

    logic  queue_full;
    logic  queue_empty;
    logic  push;
    logic  pop;
    logic  accept;
    t_cmd  front_cmd;
    t_cmd  queue_cmd;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = queue_full;
    assign accept      = i_in_valid && !queue_full;

    cfs_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_valid && o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_accept    (accept),
        .i_item      (i_in_data),
        .o_push      (push),
        .o_cmd       (front_cmd)
    );

    cfs_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (front_cmd),
        .o_full  (queue_full),
        .i_pop   (pop),
        .o_empty (queue_empty),
        .o_cmd   (queue_cmd)
    );

    cfs_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_empty     (queue_empty),
        .i_cmd       (queue_cmd),
        .o_pop       (pop),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_stall (i_out_stall)
    );

`ifndef SYNTHESIS
    a_status_alone: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.status) |->
        (!o_out_data.byte_valid && !o_out_data.field_done && !o_out_data.record_done))
        else $error("header error result carries other flags");

    a_byte_not_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_data.byte_valid) |->
        (!o_out_data.field_done && !o_out_data.record_done))
        else $error("content byte flagged as field or record end");

    a_slot_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out_data.byte_valid && !o_out_data.field_done) |->
        (o_out_data.slot == '0 && o_out_data.out_byte == '0))
        else $error("slot or byte set on a result without field content");

    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (queue_full && !pop) |-> !push)
        else $error("queue overflow");
`endif

endmodule
